/* rtl/sdg_pkg.sv */
// ----------------------------------------------------------------------------
// sdg_pkg
// Shared types, widths and constants for the three-phase sine duty generator.
// ----------------------------------------------------------------------------
package sdg_pkg;

  localparam int TABLE_SIZE_DEF = 256;

  localparam int ELAPSED_W  = 10;
  localparam int DUTY_W     = 8;
  localparam int INTERVAL_W = 20;
  localparam int SCALE_W    = 9;
  localparam int COUNT_W    = 21;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_INDEX_W = 1;

  localparam logic [INTERVAL_W-1:0] STEP_INTERVAL_RESET = 20'd781;
  localparam logic [SCALE_W-1:0]    DUTY_SCALE_RESET    = 9'd256;
  localparam logic [SCALE_W-1:0]    SCALE_ONE           = 9'd256;
  localparam logic [COUNT_W-1:0]    COUNT_MAX           = '1;

  // Sine table build: Q30 fixed point, odd Taylor series to the 15th power.
  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                 64'd110, 64'd156, 64'd210};

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_STEP_INTERVAL = 1'b0,
    CFG_DUTY_SCALE    = 1'b1
  } cfg_reg_t;

endpackage

/* rtl/sdg_if.sv */
// ----------------------------------------------------------------------------
// sdg_if
// Valid/ready channels for the elapsed-time input and the duty result output.
// ----------------------------------------------------------------------------
interface sdg_in_if;
  logic                           valid;
  logic                           ready;
  logic [sdg_pkg::ELAPSED_W-1:0]  elapsed_us;

  modport source (output valid, output elapsed_us, input ready);
  modport sink   (input valid, input elapsed_us, output ready);
endinterface

interface sdg_out_if;
  logic                        valid;
  logic                        ready;
  logic [sdg_pkg::DUTY_W-1:0]  duty_a;
  logic [sdg_pkg::DUTY_W-1:0]  duty_b;
  logic [sdg_pkg::DUTY_W-1:0]  duty_c;
  logic                        stepped;

  modport source (output valid, output duty_a, output duty_b, output duty_c,
                  output stepped, input ready);
  modport sink   (input valid, input duty_a, input duty_b, input duty_c,
                  input stepped, output ready);
endinterface

/* rtl/sdg_sine_rom.sv */
// ----------------------------------------------------------------------------
// sdg_sine_rom
// Constant sine table, floor(255*(sin+1)/2), read at three phase indexes.
// ----------------------------------------------------------------------------
module sdg_sine_rom #(
  parameter int TABLE_SIZE = sdg_pkg::TABLE_SIZE_DEF
) (
  input  logic [$clog2(TABLE_SIZE)-1:0] idx_a,
  input  logic [$clog2(TABLE_SIZE)-1:0] idx_b,
  input  logic [$clog2(TABLE_SIZE)-1:0] idx_c,
  output logic [sdg_pkg::DUTY_W-1:0]    raw_a,
  output logic [sdg_pkg::DUTY_W-1:0]    raw_b,
  output logic [sdg_pkg::DUTY_W-1:0]    raw_c
);

  // Evaluated at elaboration only; each entry folds to a constant.
  function automatic logic [sdg_pkg::DUTY_W-1:0] sine_entry(int unsigned i);
    longint unsigned u;
    longint unsigned q;
    longint unsigned r;
    longint unsigned rr;
    longint unsigned mag;
    longint unsigned v;
    longint unsigned val;
    longint unsigned theta;
    longint unsigned theta2;
    longint unsigned term;
    longint          sum;
    u = 64'(4) * longint'(i);
    q = u / TABLE_SIZE;
    r = u % TABLE_SIZE;
    if (r == 0) begin
      mag = q[0] ? sdg_pkg::Q30_ONE : 64'd0;
    end else begin
      rr     = q[0] ? (64'(TABLE_SIZE) - r) : r;
      theta  = (rr * sdg_pkg::HALF_PI_Q30) / TABLE_SIZE;
      theta2 = (theta * theta) >> 30;
      term   = theta;
      sum    = longint'(theta);
      for (int k = 1; k <= 7; k++) begin
        term = (term * theta2) >> 30;
        term = term / sdg_pkg::TAYLOR_DIV[k-1];
        if (k[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (longint'(sum) > longint'(sdg_pkg::Q30_ONE)) begin
        sum = longint'(sdg_pkg::Q30_ONE);
      end
      mag = longint'(sum);
    end
    v   = (q >= 2) ? (sdg_pkg::Q30_ONE - mag) : (sdg_pkg::Q30_ONE + mag);
    val = (64'd255 * v) >> 31;
    if (val > 64'd255) begin
      val = 64'd255;
    end
    return val[sdg_pkg::DUTY_W-1:0];
  endfunction

  logic [sdg_pkg::DUTY_W-1:0] rom [TABLE_SIZE];

  for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_rom
    assign rom[g] = sine_entry(g);
  end

  assign raw_a = rom[idx_a];
  assign raw_b = rom[idx_b];
  assign raw_c = rom[idx_c];

endmodule

/* rtl/sdg_duty_scale.sv */
// ----------------------------------------------------------------------------
// sdg_duty_scale
// Scales three raw sine values by the Q8 amplitude, truncating the result.
// ----------------------------------------------------------------------------
module sdg_duty_scale (
  input  logic [sdg_pkg::SCALE_W-1:0] scale,
  input  logic [sdg_pkg::DUTY_W-1:0]  raw_a,
  input  logic [sdg_pkg::DUTY_W-1:0]  raw_b,
  input  logic [sdg_pkg::DUTY_W-1:0]  raw_c,
  output logic [sdg_pkg::DUTY_W-1:0]  duty_a,
  output logic [sdg_pkg::DUTY_W-1:0]  duty_b,
  output logic [sdg_pkg::DUTY_W-1:0]  duty_c
);

  localparam int PROD_W = sdg_pkg::DUTY_W + sdg_pkg::SCALE_W;

  logic [sdg_pkg::SCALE_W-1:0] scale_sat;
  logic [PROD_W-1:0]           prod_a;
  logic [PROD_W-1:0]           prod_b;
  logic [PROD_W-1:0]           prod_c;

  // Anything above unity amplitude is clamped to unity.
  assign scale_sat = (scale > sdg_pkg::SCALE_ONE) ? sdg_pkg::SCALE_ONE : scale;

  assign prod_a = PROD_W'(raw_a) * PROD_W'(scale_sat);
  assign prod_b = PROD_W'(raw_b) * PROD_W'(scale_sat);
  assign prod_c = PROD_W'(raw_c) * PROD_W'(scale_sat);

  assign duty_a = prod_a[2*sdg_pkg::DUTY_W-1:sdg_pkg::DUTY_W];
  assign duty_b = prod_b[2*sdg_pkg::DUTY_W-1:sdg_pkg::DUTY_W];
  assign duty_c = prod_c[2*sdg_pkg::DUTY_W-1:sdg_pkg::DUTY_W];

endmodule

/* rtl/three_phase_sine_duty_generator.sv */
// ----------------------------------------------------------------------------
// three_phase_sine_duty_generator
// Steps a sine table on elapsed time and produces three phase duty values.
// ----------------------------------------------------------------------------
// One transaction is taken every clock cycle when the output side keeps up.
// Each accepted transaction lands in an input register; the elapsed-counter
// compare, the three sine table reads and the three 8x9 multiplies run
// between that register and the result register. The result register and
// the input register together hold up to two transactions, so one more
// transaction is taken while a result waits. The sine table is constant
// logic, so no start-up pass is needed after reset. Write the configuration
// registers only while no transaction is in flight.
module three_phase_sine_duty_generator #(
  parameter int TABLE_SIZE = sdg_pkg::TABLE_SIZE_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  sdg_in_if.sink                             in_ch,
  sdg_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [sdg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sdg_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int IDX_W   = $clog2(TABLE_SIZE);
  localparam int PHASE_B = TABLE_SIZE / 3;
  localparam int PHASE_C = (2 * TABLE_SIZE) / 3;

  logic [sdg_pkg::INTERVAL_W-1:0] step_interval_us;
  logic [sdg_pkg::SCALE_W-1:0]    duty_scale;

  logic                           s1_valid;
  logic [sdg_pkg::ELAPSED_W-1:0]  s1_elapsed;
  logic                           advance;

  logic [sdg_pkg::COUNT_W-1:0]    elapsed_count;
  logic [IDX_W-1:0]               base_index;
  logic                           out_valid;
  logic [sdg_pkg::DUTY_W-1:0]     duty_a;
  logic [sdg_pkg::DUTY_W-1:0]     duty_b;
  logic [sdg_pkg::DUTY_W-1:0]     duty_c;
  logic                           stepped;

  logic [sdg_pkg::COUNT_W:0]      count_sum;
  logic [sdg_pkg::COUNT_W-1:0]    count_sat;
  logic                           step;
  logic [IDX_W:0]                 idx_b_sum;
  logic [IDX_W:0]                 idx_c_sum;
  logic [IDX_W-1:0]               idx_b;
  logic [IDX_W-1:0]               idx_c;
  logic [sdg_pkg::DUTY_W-1:0]     raw_a;
  logic [sdg_pkg::DUTY_W-1:0]     raw_b;
  logic [sdg_pkg::DUTY_W-1:0]     raw_c;
  logic [sdg_pkg::DUTY_W-1:0]     new_a;
  logic [sdg_pkg::DUTY_W-1:0]     new_b;
  logic [sdg_pkg::DUTY_W-1:0]     new_c;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_interval_us <= sdg_pkg::STEP_INTERVAL_RESET;
      duty_scale       <= sdg_pkg::DUTY_SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sdg_pkg::CFG_STEP_INTERVAL: step_interval_us <= cfg_data[sdg_pkg::INTERVAL_W-1:0];
        sdg_pkg::CFG_DUTY_SCALE:    duty_scale       <= cfg_data[sdg_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance     = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_elapsed <= in_ch.elapsed_us;
    end
  end

  // Saturating elapsed counter and step decision.
  assign count_sum = {1'b0, elapsed_count} + (sdg_pkg::COUNT_W + 1)'(s1_elapsed);
  assign count_sat = count_sum[sdg_pkg::COUNT_W] ? sdg_pkg::COUNT_MAX
                                                 : count_sum[sdg_pkg::COUNT_W-1:0];
  assign step      = count_sat >= sdg_pkg::COUNT_W'(step_interval_us);

  // Phase offsets, wrapped around the table.
  assign idx_b_sum = {1'b0, base_index} + (IDX_W + 1)'(PHASE_B);
  assign idx_c_sum = {1'b0, base_index} + (IDX_W + 1)'(PHASE_C);
  assign idx_b = (idx_b_sum >= (IDX_W + 1)'(TABLE_SIZE))
                 ? IDX_W'(idx_b_sum - (IDX_W + 1)'(TABLE_SIZE)) : idx_b_sum[IDX_W-1:0];
  assign idx_c = (idx_c_sum >= (IDX_W + 1)'(TABLE_SIZE))
                 ? IDX_W'(idx_c_sum - (IDX_W + 1)'(TABLE_SIZE)) : idx_c_sum[IDX_W-1:0];

  sdg_sine_rom #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_rom (
    .idx_a (base_index),
    .idx_b (idx_b),
    .idx_c (idx_c),
    .raw_a (raw_a),
    .raw_b (raw_b),
    .raw_c (raw_c)
  );

  sdg_duty_scale u_scale (
    .scale  (duty_scale),
    .raw_a  (raw_a),
    .raw_b  (raw_b),
    .raw_c  (raw_c),
    .duty_a (new_a),
    .duty_b (new_b),
    .duty_c (new_c)
  );

  // Result register; the duty registers double as the held phase values.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      elapsed_count <= '0;
      base_index    <= '0;
      duty_a        <= '0;
      duty_b        <= '0;
      duty_c        <= '0;
      stepped       <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
      stepped   <= step;
      if (step) begin
        elapsed_count <= '0;
        base_index    <= (base_index == IDX_W'(TABLE_SIZE - 1)) ? '0 : base_index + IDX_W'(1);
        duty_a        <= new_a;
        duty_b        <= new_b;
        duty_c        <= new_c;
      end else begin
        elapsed_count <= count_sat;
      end
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.duty_a  = duty_a;
  assign out_ch.duty_b  = duty_b;
  assign out_ch.duty_c  = duty_c;
  assign out_ch.stepped = stepped;

endmodule

/* rtl/sdg_checker.sv */
// ----------------------------------------------------------------------------
// sdg_checker
// Port-level checks for the three-phase sine duty generator.
// ----------------------------------------------------------------------------
module sdg_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [sdg_pkg::DUTY_W-1:0]       duty_a,
  input logic [sdg_pkg::DUTY_W-1:0]       duty_b,
  input logic [sdg_pkg::DUTY_W-1:0]       duty_c,
  input logic                             stepped,
  input logic                             cfg_we,
  input logic [sdg_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input logic [sdg_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic                       in_acc;
  logic                       out_acc;
  logic [2:0]                 occupancy;
  logic                       scale_zero;
  logic [sdg_pkg::DUTY_W-1:0] last_a;
  logic [sdg_pkg::DUTY_W-1:0] last_b;
  logic [sdg_pkg::DUTY_W-1:0] last_c;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Transactions inside the block, and the last delivered duties.
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy  <= '0;
      scale_zero <= 1'b0;
      last_a     <= '0;
      last_b     <= '0;
      last_c     <= '0;
    end else begin
      occupancy <= occupancy + 3'(in_acc) - 3'(out_acc);
      if (cfg_we && (cfg_index == sdg_pkg::CFG_DUTY_SCALE)) begin
        scale_zero <= (cfg_data[sdg_pkg::SCALE_W-1:0] == '0);
      end
      if (out_acc) begin
        last_a <= duty_a;
        last_b <= duty_b;
        last_c <= duty_c;
      end
    end
  end

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(duty_a) && $stable(duty_b)
                                && $stable(duty_c) && $stable(stepped))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> occupancy != 3'd0)
    else $error("result shown with no transaction in flight");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    occupancy <= 3'd2)
    else $error("more transactions held than the block has room for");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_acc && !stepped |-> duty_a == last_a && duty_b == last_b && duty_c == last_c)
    else $error("duties changed without a table step");

  a_zero_scale: assert property (@(posedge clk) disable iff (rst)
    out_valid && stepped && scale_zero |-> duty_a == '0 && duty_b == '0 && duty_c == '0)
    else $error("nonzero duty with zero amplitude");

endmodule

bind three_phase_sine_duty_generator sdg_checker u_sdg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .duty_a    (out_ch.duty_a),
  .duty_b    (out_ch.duty_b),
  .duty_c    (out_ch.duty_c),
  .stepped   (out_ch.stepped),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);
